@@ rtl/core/wodr_pkg.sv @@
// Shared constants, types and arithmetic helpers of the wheel odometry unit.
package wodr_pkg;

	localparam int ANGLE_ITERATIONS_DEF = 24;
	localparam int MUL_W = 40;
	localparam int PROD_W = 2 * MUL_W;
	localparam int CS_W = 34;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] KIND_LEFT = 2'd0;
	localparam logic [1:0] KIND_RIGHT = 2'd1;
	localparam logic [1:0] KIND_STEER = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEELBASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd3;

	localparam logic [31:0] RATE_GAIN_RST = 32'd65536;
	localparam logic [23:0] HALF_RADIUS_RST = 24'd157286;
	localparam logic [23:0] INV_WHEELBASE_RST = 24'd1048576;
	localparam logic [23:0] TICK_PERIOD_RST = 24'd335544;

	localparam logic signed [17:0] STEER_LIMIT = 18'sd98304;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [MUL_W-1:0] RAD_TO_BA = 40'sd174992710548;

	typedef struct packed {
		logic signed [CS_W-1:0] c;
		logic signed [CS_W-1:0] s;
	} cs_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > 80'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -80'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
		input int unsigned s);
		logic signed [PROD_W-1:0] t;
		t = v + (PROD_W'(1) << (s - 1));
		return t >>> s;
	endfunction

	function automatic logic [31:0] rad_angle(input logic signed [PROD_W-1:0] p);
		logic [55:0] t;
		t = p[55:0] + 56'd8388608;
		return t[55:24];
	endfunction

endpackage

@@ rtl/core/wodr_if.sv @@
// Request and result channel interfaces of the wheel odometry unit.
interface wodr_in_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic signed [31:0] encoder_count;
	logic signed [17:0] steer_angle;

	modport source(output valid, kind, encoder_count, steer_angle, input ready);
	modport sink(input valid, kind, encoder_count, steer_angle, output ready);
endinterface

interface wodr_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] speed;
	logic [31:0] heading;

	modport source(output valid, vel_x, vel_y, speed, heading, input ready);
	modport sink(input valid, vel_x, vel_y, speed, heading, output ready);
endinterface

@@ rtl/core/wodr_mul.sv @@
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module wodr_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [wodr_pkg::MUL_W-1:0] a,
	input logic signed [wodr_pkg::MUL_W-1:0] b,
	output logic signed [wodr_pkg::PROD_W-1:0] prod,
	output logic done
);
	import wodr_pkg::*;

	localparam int CW = $clog2(MUL_W);

	logic signed [MUL_W-1:0] a_q;
	logic signed [MUL_W-1:0] hi_q;
	logic [MUL_W-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic last;
	logic signed [MUL_W:0] addend;
	logic signed [MUL_W:0] t;

	always_comb begin
		last = (cnt_q == CW'(MUL_W - 1));
		addend = '0;
		if (lo_q[0]) begin
			addend = last ? -{a_q[MUL_W-1], a_q} : {a_q[MUL_W-1], a_q};
		end
		t = {hi_q[MUL_W-1], hi_q} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= t[MUL_W:1];
			lo_q <= {t[0], lo_q[MUL_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};
	assign done = done_q;

endmodule

@@ rtl/core/wodr_cordic.sv @@
// Iterative CORDIC that turns a binary angle into cosine and sine, one step per cycle.
module wodr_cordic #(
	parameter int ITERATIONS = wodr_pkg::ANGLE_ITERATIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] angle,
	output wodr_pkg::cs_t res,
	output logic done
);
	import wodr_pkg::*;

	localparam int CW = $clog2(ITERATIONS);

	logic signed [CS_W-1:0] x_q;
	logic signed [CS_W-1:0] y_q;
	logic signed [32:0] z_q;
	logic flip_q;
	logic [CW-1:0] i_q;
	logic run_q;
	logic done_q;
	logic flip;
	logic [31:0] folded;
	logic signed [CS_W-1:0] dx;
	logic signed [CS_W-1:0] dy;
	logic signed [32:0] at;

	always_comb begin
		flip = angle[31] ^ angle[30];
		folded = flip ? angle + 32'h80000000 : angle;
		dx = x_q >>> i_q;
		dy = y_q >>> i_q;
		at = {1'b0, atan_lut(5'(i_q))};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == CW'(ITERATIONS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= {folded[31], folded};
			flip_q <= flip;
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + at;
			end
		end
	end

	assign res.c = flip_q ? -x_q : x_q;
	assign res.s = flip_q ? -y_q : y_q;
	assign done = done_q;

endmodule

@@ rtl/core/wheel_odometry_dead_reckoning_unit.sv @@
// Top level of the wheel odometry dead-reckoning unit.
// An encoder count request occupies the unit for one serial multiply.
// A steering request is stored while the unit stays idle; a tick gives its result after
// eight serial multiplies, two CORDIC passes and a serial division.
// One request is worked on at a time; a tick's result waits until any older result has left.
// Reset clears all wheel and heading state and loads the default register values.
module wheel_odometry_dead_reckoning_unit #(
	parameter int ANGLE_ITERATIONS = wodr_pkg::ANGLE_ITERATIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [wodr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	wodr_in_if.sink item,
	wodr_out_if.source result
);
	import wodr_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RATE = 4'd1;
	localparam logic [3:0] ST_SPEED = 4'd2;
	localparam logic [3:0] ST_STEER = 4'd3;
	localparam logic [3:0] ST_CS_STEER = 4'd4;
	localparam logic [3:0] ST_P1 = 4'd5;
	localparam logic [3:0] ST_P2 = 4'd6;
	localparam logic [3:0] ST_P3 = 4'd7;
	localparam logic [3:0] ST_DIV = 4'd8;
	localparam logic [3:0] ST_YAW = 4'd9;
	localparam logic [3:0] ST_CS_YAW = 4'd10;
	localparam logic [3:0] ST_VX = 4'd11;
	localparam logic [3:0] ST_VY = 4'd12;
	localparam logic [3:0] ST_OUT = 4'd13;

	localparam int DIV_W = 64;
	localparam int DIV_CW = $clog2(DIV_W);

	logic [3:0] state_q;
	logic go_q;
	logic side_q;
	logic [DIV_CW-1:0] cnt_q;
	logic ovalid_q;
	logic [31:0] rate_gain_q;
	logic [23:0] half_radius_q;
	logic [23:0] inv_wheelbase_q;
	logic [23:0] tick_period_q;
	logic [31:0] last_left_q;
	logic [31:0] last_right_q;
	logic signed [31:0] left_rate_q;
	logic signed [31:0] right_rate_q;
	logic signed [17:0] steer_q;
	logic [31:0] yaw_q;

	logic [31:0] diff_q;
	logic signed [31:0] speed_q;
	logic [31:0] ang_q;
	logic signed [CS_W-1:0] c_q;
	logic signed [CS_W-1:0] s_q;
	logic signed [MUL_W-1:0] p_q;
	logic neg_q;
	logic [DIV_W-1:0] dq_q;
	logic [CS_W-1:0] rem_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] spd_q;
	logic [31:0] hd_q;

	logic mul_start;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_prod;
	logic mul_done;
	logic cs_start;
	logic [31:0] cs_angle;
	cs_t cs_res;
	logic cs_done;

	logic signed [17:0] steer_cl;
	logic [CS_W-1:0] div_w;
	logic [CS_W:0] r2;
	logic ge;
	logic [CS_W-1:0] nrem;
	logic signed [MUL_W-1:0] qmag;
	logic signed [MUL_W-1:0] quot;
	logic out_free;

	wodr_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.prod(mul_prod),
		.done(mul_done)
	);

	wodr_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cs_start),
		.angle(cs_angle),
		.res(cs_res),
		.done(cs_done)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_start = 1'b0;
		case (state_q)
			ST_RATE: begin
				mul_a = {8'd0, rate_gain_q};
				mul_b = 40'(signed'(diff_q));
				mul_start = go_q;
			end
			ST_SPEED: begin
				mul_a = {16'd0, half_radius_q};
				mul_b = 40'(left_rate_q) + 40'(right_rate_q);
				mul_start = go_q;
			end
			ST_STEER: begin
				mul_a = RAD_TO_BA;
				mul_b = 40'(steer_q);
				mul_start = go_q;
			end
			ST_P1: begin
				mul_a = {16'd0, inv_wheelbase_q};
				mul_b = 40'(speed_q);
				mul_start = go_q;
			end
			ST_P2: begin
				mul_a = {16'd0, tick_period_q};
				mul_b = p_q;
				mul_start = go_q;
			end
			ST_P3: begin
				mul_a = 40'(s_q);
				mul_b = p_q;
				mul_start = go_q;
			end
			ST_YAW: begin
				mul_a = RAD_TO_BA;
				mul_b = quot;
				mul_start = go_q;
			end
			ST_VX: begin
				mul_a = 40'(c_q);
				mul_b = 40'(speed_q);
				mul_start = go_q;
			end
			ST_VY: begin
				mul_a = 40'(s_q);
				mul_b = 40'(speed_q);
				mul_start = go_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		cs_start = go_q && (state_q == ST_CS_STEER || state_q == ST_CS_YAW);
		cs_angle = (state_q == ST_CS_STEER) ? ang_q : yaw_q;
		if (item.steer_angle > STEER_LIMIT) begin
			steer_cl = STEER_LIMIT;
		end else if (item.steer_angle < -STEER_LIMIT) begin
			steer_cl = -STEER_LIMIT;
		end else begin
			steer_cl = item.steer_angle;
		end
		div_w = (c_q < 34'sd1) ? 34'd1 : c_q;
		r2 = {rem_q, dq_q[DIV_W-1]};
		ge = (r2 >= {1'b0, div_w});
		nrem = ge ? CS_W'(r2 - {1'b0, div_w}) : r2[CS_W-1:0];
		qmag = dq_q[MUL_W-1:0];
		quot = neg_q ? -qmag : qmag;
		out_free = !ovalid_q || result.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			side_q <= 1'b0;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			rate_gain_q <= RATE_GAIN_RST;
			half_radius_q <= HALF_RADIUS_RST;
			inv_wheelbase_q <= INV_WHEELBASE_RST;
			tick_period_q <= TICK_PERIOD_RST;
			last_left_q <= '0;
			last_right_q <= '0;
			left_rate_q <= '0;
			right_rate_q <= '0;
			steer_q <= '0;
			yaw_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE_GAIN: rate_gain_q <= cfg_data;
					REG_HALF_RADIUS: half_radius_q <= cfg_data[23:0];
					REG_INV_WHEELBASE: inv_wheelbase_q <= cfg_data[23:0];
					REG_TICK_PERIOD: tick_period_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (ovalid_q && result.ready && state_q != ST_OUT) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						case (item.kind)
							KIND_LEFT: begin
								last_left_q <= item.encoder_count;
								side_q <= 1'b0;
								state_q <= ST_RATE;
								go_q <= 1'b1;
							end
							KIND_RIGHT: begin
								last_right_q <= item.encoder_count;
								side_q <= 1'b1;
								state_q <= ST_RATE;
								go_q <= 1'b1;
							end
							KIND_STEER: begin
								steer_q <= steer_cl;
							end
							default: begin
								state_q <= ST_SPEED;
								go_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RATE: begin
					if (mul_done) begin
						if (side_q) begin
							right_rate_q <= sat32(mul_prod);
						end else begin
							left_rate_q <= sat32(mul_prod);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SPEED: begin
					if (mul_done) begin
						state_q <= ST_STEER;
						go_q <= 1'b1;
					end
				end
				ST_STEER: begin
					if (mul_done) begin
						state_q <= ST_CS_STEER;
						go_q <= 1'b1;
					end
				end
				ST_CS_STEER: begin
					if (cs_done) begin
						state_q <= ST_P1;
						go_q <= 1'b1;
					end
				end
				ST_P1: begin
					if (mul_done) begin
						state_q <= ST_P2;
						go_q <= 1'b1;
					end
				end
				ST_P2: begin
					if (mul_done) begin
						state_q <= ST_P3;
						go_q <= 1'b1;
					end
				end
				ST_P3: begin
					if (mul_done) begin
						state_q <= ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CW'(DIV_W - 1)) begin
						state_q <= ST_YAW;
						go_q <= 1'b1;
					end
				end
				ST_YAW: begin
					if (mul_done) begin
						yaw_q <= yaw_q + rad_angle(mul_prod);
						state_q <= ST_CS_YAW;
						go_q <= 1'b1;
					end
				end
				ST_CS_YAW: begin
					if (cs_done) begin
						state_q <= ST_VX;
						go_q <= 1'b1;
					end
				end
				ST_VX: begin
					if (mul_done) begin
						state_q <= ST_VY;
						go_q <= 1'b1;
					end
				end
				ST_VY: begin
					if (mul_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					diff_q <= item.encoder_count -
						((item.kind == KIND_RIGHT) ? last_right_q : last_left_q);
				end
			end
			ST_SPEED: begin
				if (mul_done) begin
					speed_q <= sat32(rnd_shift(mul_prod, 20));
				end
			end
			ST_STEER: begin
				if (mul_done) begin
					ang_q <= rad_angle(mul_prod);
				end
			end
			ST_CS_STEER, ST_CS_YAW: begin
				if (cs_done) begin
					c_q <= cs_res.c;
					s_q <= cs_res.s;
				end
			end
			ST_P1: begin
				if (mul_done) begin
					p_q <= MUL_W'(rnd_shift(mul_prod, 20));
				end
			end
			ST_P2: begin
				if (mul_done) begin
					p_q <= MUL_W'(sat32(rnd_shift(mul_prod, 24)));
				end
			end
			ST_P3: begin
				if (mul_done) begin
					neg_q <= mul_prod[PROD_W-1];
					dq_q <= DIV_W'(mul_prod[PROD_W-1] ? -mul_prod : mul_prod);
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				dq_q <= {dq_q[DIV_W-2:0], ge};
				rem_q <= nrem;
			end
			ST_VX: begin
				if (mul_done) begin
					vx_q <= sat32(rnd_shift(mul_prod, 30));
				end
			end
			ST_VY: begin
				if (mul_done) begin
					vy_q <= sat32(rnd_shift(mul_prod, 30));
				end
			end
			ST_OUT: begin
				if (out_free) begin
					x_q <= vx_q;
					y_q <= vy_q;
					spd_q <= speed_q;
					hd_q <= yaw_q;
				end
			end
			default: ;
		endcase
	end

	assign item.ready = (state_q == ST_IDLE);
	assign result.valid = ovalid_q;
	assign result.vel_x = x_q;
	assign result.vel_y = y_q;
	assign result.speed = spd_q;
	assign result.heading = hd_q;

`ifndef ASSERT_OFF
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_RATE || state_q == ST_SPEED || state_q == ST_STEER ||
			state_q == ST_P1 || state_q == ST_P2 || state_q == ST_P3 ||
			state_q == ST_YAW || state_q == ST_VX || state_q == ST_VY))
		else $error("Multiplier finished outside a multiply step.");

	a_cs_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cs_done |-> (state_q == ST_CS_STEER || state_q == ST_CS_YAW))
		else $error("CORDIC finished outside a sine and cosine step.");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind == KIND_TICK) |=> !item.ready)
		else $error("Tick request did not start the sequencer.");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_w))
		else $error("Division remainder is not below the divisor.");
`endif

endmodule
